/* design/sle_pkg.sv */
// Package with the shared types and constants of the sorted list engine.
package sle_pkg;

	// Number of entries in the sorted table.
	localparam int DEPTH = 16;
	// Width of the internal entry counter.
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Width of the entry count field in a result transaction.
	localparam int COUNT_FIELD_W = 5;
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_POP    = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_e;

	// One command transaction.
	typedef struct packed {
		cmd_e  command;
		word_t value;
	} request_t;

	// One result transaction.
	typedef struct packed {
		status_e                  status;
		word_t                    popped_value;
		logic [COUNT_FIELD_W-1:0] entry_count;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch;
		logic    ins;
		logic    del;
		logic    pop;
		logic    post;
		status_e status;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_e cmd;
		logic full;
		logic empty;
		logic found;
	} flags_t;

endpackage

/* design/sle_datapath.sv */
// Datapath of the sorted list engine: the entry row, parallel compare and shift.
module sle_datapath import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  request_t request,
	input  ctl_t     ctl,
	output flags_t   flags,
	output result_t  result
);

	cmd_e  cmd_q;
	word_t value_q;
	word_t cell_q [DEPTH];
	cnt_t  count_q;
	result_t result_q;

	logic [DEPTH-1:0] lt;
	logic [DEPTH-1:0] eq;
	word_t ins_val [DEPTH];
	word_t nxt_val [DEPTH];
	cnt_t  count_next;

	// Compare every valid entry against the operand in parallel.
	// The table is ascending, so the less-than vector is a prefix and the
	// first entry that is not less marks the insert or delete position.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic valid;
		assign valid = (cnt_t'(i) < count_q);
		assign lt[i] = valid && (cell_q[i] < value_q);
		assign eq[i] = valid && (cell_q[i] == value_q);

		if (i == 0) begin : g_head
			assign ins_val[i] = lt[i] ? cell_q[i] : value_q;
		end else begin : g_body
			assign ins_val[i] = lt[i] ? cell_q[i] : (lt[i-1] ? value_q : cell_q[i-1]);
		end

		if (i == DEPTH - 1) begin : g_tail
			assign nxt_val[i] = cell_q[i];
		end else begin : g_inner
			assign nxt_val[i] = cell_q[i+1];
		end

		// Entry registers hold no reset value; entries past the count never affect a result.
		always_ff @(posedge clk) begin
			if (ctl.ins) begin
				cell_q[i] <= ins_val[i];
			end else if (ctl.pop || (ctl.del && !lt[i])) begin
				cell_q[i] <= nxt_val[i];
			end
		end
	end

	assign flags.cmd   = cmd_q;
	assign flags.full  = (count_q == cnt_t'(DEPTH));
	assign flags.empty = (count_q == '0);
	assign flags.found = |eq;

	// Entry count after the command.
	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + cnt_t'(1);
		end else if (ctl.del || ctl.pop) begin
			count_next = count_q - cnt_t'(1);
		end
	end

	// Latch the accepted command transaction.
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q   <= request.command;
			value_q <= request.value;
		end
	end

	// Entry counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Result register, loaded on the controller's post strobe and held until the next one.
	always_ff @(posedge clk) begin
		if (ctl.post) begin
			result_q.status       <= ctl.status;
			result_q.popped_value <= ctl.pop ? cell_q[0] : '0;
			result_q.entry_count  <= COUNT_FIELD_W'(count_next);
		end
	end

	assign result = result_q;

endmodule

/* design/sle_ctrl.sv */
// Controller of the sorted list engine: accept and execute sequencing.
module sle_ctrl import sle_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  flags_t flags,
	output ctl_t   ctl,
	output logic   busy,
	output logic   done
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_e;

	state_e state_q;
	logic   done_q;

	// Decode the latched command against the table flags.
	always_comb begin
		ctl = '0;
		ctl.status = ST_OK;
		ctl.latch = (state_q == S_IDLE) && start;
		if (state_q == S_EXEC) begin
			ctl.post = 1'b1;
			unique case (flags.cmd)
				CMD_INSERT: begin
					if (flags.full) begin
						ctl.status = ST_FULL;
					end else begin
						ctl.ins = 1'b1;
					end
				end
				CMD_SEARCH: begin
					ctl.status = flags.found ? ST_OK : ST_NOT_FOUND;
				end
				CMD_DELETE: begin
					if (flags.found) begin
						ctl.del = 1'b1;
					end else begin
						ctl.status = ST_NOT_FOUND;
					end
				end
				CMD_POP: begin
					if (flags.empty) begin
						ctl.status = ST_EMPTY;
					end else begin
						ctl.pop = 1'b1;
					end
				end
				default: begin
					ctl.status = ST_OK;
				end
			endcase
		end
	end

	// State and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == S_EXEC);
	assign done = done_q;

endmodule

/* design/sorted_list_engine_core.sv */
// Sorted list engine: a table of signed 32-bit values kept in ascending order.
//
// A command transaction is taken when start is high and busy is low. The next
// cycle is the execute cycle, with busy high: all DEPTH entries are compared
// with the operand at once and the row shifts by one place to insert or remove.
// The result is registered from the execute cycle and put on result with done
// high for exactly one cycle; a new command may be started while its result is
// shown. The receiver cannot stall. The table needs no clearing after reset.
module sorted_list_engine_core import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  request_t request,
	output logic     busy,
	output logic     done,
	output result_t  result
);

	ctl_t   ctl;
	flags_t flags;

	// Command sequencing.
	sle_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// Entry row and result register.
	sle_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.flags   (flags),
		.result  (result)
	);

endmodule

/* design/sle_checker.sv */
// Port checker for the sorted list engine and its bind to the top level.
module sle_checker import sle_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// An accepted transaction moves the block to its execute cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted transaction");

	// The execute cycle lasts exactly one cycle and is followed by a result.
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("execute cycle not followed by a result");

	// A result only follows an execute cycle.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding execute cycle");

	// A dropped insert reports a full table.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |->
			result.entry_count == COUNT_FIELD_W'(DEPTH))
		else $error("full status with a table that is not full");

	// Only a successful transaction may carry a popped value.
	a_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.popped_value == '0)
		else $error("popped value on a failed transaction");

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (.*);

/* tb/sle_result_checker.sv */
// Checker for the sorted list engine: predicts each result and compares it with the block.
module sle_result_checker import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  request_t request,
	input  logic     done,
	input  result_t  result,
	output int       fail_count,
	output int       pending
);

	// Shadow copy of the sorted table and its fill level.
	word_t   sorted_table [DEPTH];
	int      table_count;
	result_t awaited_results [$];
	int      errors;

	initial begin
		table_count = 0;
		errors      = 0;
		fail_count  = 0;
		pending     = 0;
	end

	// Apply one command to the shadow table and return the result it should give.
	function automatic result_t apply_command(request_t req);
		result_t res;
		word_t   operand;
		int      pos;
		int      k;
		operand          = req.value;
		res.status       = ST_OK;
		res.popped_value = '0;
		// Position of the first entry that is not smaller than the operand.
		pos = 0;
		while (pos < table_count && sorted_table[pos] < operand)
			pos++;
		case (req.command)
			CMD_INSERT: begin
				if (table_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (k = table_count; k > pos; k--)
						sorted_table[k] = sorted_table[k-1];
					sorted_table[pos] = operand;
					table_count++;
				end
			end
			CMD_SEARCH: begin
				if (!(pos < table_count && sorted_table[pos] == operand))
					res.status = ST_NOT_FOUND;
			end
			CMD_DELETE: begin
				if (pos < table_count && sorted_table[pos] == operand) begin
					for (k = pos; k < table_count - 1; k++)
						sorted_table[k] = sorted_table[k+1];
					table_count--;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			CMD_POP: begin
				if (table_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.popped_value = sorted_table[0];
					for (k = 0; k < table_count - 1; k++)
						sorted_table[k] = sorted_table[k+1];
					table_count--;
				end
			end
		endcase
		res.entry_count = COUNT_FIELD_W'(table_count);
		return res;
	endfunction

	// Retire results first, since a result always belongs to an earlier transaction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with no command waiting: status %0d popped %0d count %0d",
						$time, result.status, result.popped_value, result.entry_count);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
						errors++;
					end
					if (result.popped_value !== want.popped_value) begin
						$display("%0t: popped_value expected %0d actual %0d",
							$time, want.popped_value, result.popped_value);
						errors++;
					end
					if (result.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.entry_count, result.entry_count);
						errors++;
					end
				end
			end
			if (start && !busy)
				awaited_results.push_back(apply_command(request));
		end
		fail_count <= errors;
		pending    <= awaited_results.size();
	end

endmodule

/* tb/sorted_list_engine_core_test.sv */
// Top of the sorted list engine testbench: clock, reset, command stimulus and verdict.
module sorted_list_engine_core_test;
	import sle_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int SEGMENT_LEN  = 60;

	// Command mixes used to walk the table between empty and full.
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

	logic     clk;
	logic     arst_n;
	logic     start;
	request_t request;
	logic     busy;
	logic     done;
	result_t  result;
	int       fail_count;
	int       pending;
	int       idle_pct;

	sorted_list_engine_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	sle_result_checker checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offer one command transaction, with random idle cycles ahead of it.
	task automatic issue(cmd_e cmd, word_t operand);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= '{command: cmd, value: operand};
		do @(posedge clk); while (busy);
	endtask

	// The run ends in failure if no transaction moves for too long.
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stalled = 0;
			else
				stalled++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		mix_e  mix;
		cmd_e  cmd;
		word_t operand;
		int    pick;
		int    k;
		arst_n   = 1'b0;
		start    = 1'b0;
		request  = '0;
		idle_pct = 28;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: operations on the empty table.
		issue(CMD_POP, 32'sh0);
		issue(CMD_DELETE, 32'sh5);
		issue(CMD_SEARCH, 32'sh0);
		// Extremes and a duplicate, which must land in front of its equal.
		issue(CMD_INSERT, 32'sh7fffffff);
		issue(CMD_INSERT, 32'sh80000000);
		issue(CMD_INSERT, 32'sh0);
		issue(CMD_INSERT, -32'sh1);
		issue(CMD_INSERT, 32'sh80000000);
		issue(CMD_SEARCH, 32'sh7fffffff);
		issue(CMD_SEARCH, 32'sh5);
		issue(CMD_DELETE, -32'sh1);
		issue(CMD_DELETE, 32'sh7);
		issue(CMD_POP, 32'shffffffff);
		// Fill the table and then insert into the full table.
		for (k = 0; k < 13; k++)
			issue(CMD_INSERT, word_t'(k * 3 - 20));
		issue(CMD_INSERT, 32'sh12345678);

		// Random part in segments that lean towards filling or draining the table.
		mix = MIX_BALANCED;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % SEGMENT_LEN == 0)
				mix = mix_e'($urandom_range(2));
			idle_pct = (k >= 700 && k < 1000) ? 0 : 28;
			pick = $urandom_range(99);
			case (mix)
				MIX_FILL:
					cmd = (pick < 65) ? CMD_INSERT : (pick < 80) ? CMD_SEARCH :
						(pick < 90) ? CMD_DELETE : CMD_POP;
				MIX_DRAIN:
					cmd = (pick < 15) ? CMD_INSERT : (pick < 30) ? CMD_SEARCH :
						(pick < 60) ? CMD_DELETE : CMD_POP;
				default:
					cmd = (pick < 30) ? CMD_INSERT : (pick < 55) ? CMD_SEARCH :
						(pick < 80) ? CMD_DELETE : CMD_POP;
			endcase
			// Mostly a narrow band so that searches and deletes find matches.
			pick = $urandom_range(99);
			if (pick < 55) begin
				operand = word_t'(int'($urandom_range(19)) - 10);
			end else if (pick < 65) begin
				case ($urandom_range(3))
					0: operand = 32'sh7fffffff;
					1: operand = 32'sh80000000;
					2: operand = 32'sh0;
					default: operand = -32'sh1;
				endcase
			end else begin
				operand = word_t'($urandom);
			end
			issue(cmd, operand);
		end
		start <= 1'b0;

		// Let every outstanding result come back, then a few more cycles.
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
